>>> design/assert_macros.svh
// assertion macros for the checker gfinv_chk
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define GFI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gfinv assertion failed");

// clocked property that also holds while reset is held
`define GFI_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("gfinv reset assertion failed");

`endif

>>> design/gfinv_pkg.sv
// types, codes and field arithmetic for the gf(2^8) inverter
// no dependencies
package gfinv_pkg;

    localparam int GFI_BYTE_W  = 8;
    localparam int GFI_DIGIT_W = 2;
    localparam logic [GFI_BYTE_W-1:0] GFI_REDUCE = 8'h1B;
    localparam logic [GFI_BYTE_W:0]   GFI_POLY   = 9'h11B;

    typedef logic [GFI_BYTE_W-1:0] t_byte;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // products of the addition chain, named after the exponent they produce
    typedef enum logic [1:0] {
        STEP_X3,
        STEP_X7,
        STEP_X63,
        STEP_X127
    } t_step;

    typedef struct packed {
        logic  load;
        logic  run;
        logic  next;
        t_step step;
        logic  out_load;
    } t_gfi_ctl;

    function automatic t_byte gf_xtime(input t_byte a);
        t_byte r;
        r = {a[GFI_BYTE_W-2:0], 1'b0};
        if (a[GFI_BYTE_W-1]) begin
            r = r ^ GFI_REDUCE;
        end
        return r;
    endfunction

    // squaring is linear: spread the bits, then fold the top seven down
    function automatic t_byte gf_sq(input t_byte a);
        logic [2*GFI_BYTE_W-2:0] t;
        t = '0;
        for (int i = 0; i < GFI_BYTE_W; i++) begin
            t[2*i] = a[i];
        end
        for (int k = 2*GFI_BYTE_W-2; k >= GFI_BYTE_W; k--) begin
            if (t[k]) begin
                t[k -: GFI_BYTE_W+1] = t[k -: GFI_BYTE_W+1] ^ GFI_POLY;
            end
        end
        return t[GFI_BYTE_W-1:0];
    endfunction

    function automatic t_byte gf_sq3(input t_byte a);
        return gf_sq(gf_sq(gf_sq(a)));
    endfunction

    function automatic t_step step_succ(input t_step s);
        t_step r;
        case (s)
            STEP_X3:  r = STEP_X7;
            STEP_X7:  r = STEP_X63;
            STEP_X63: r = STEP_X127;
            default:  r = STEP_X127;
        endcase
        return r;
    endfunction

endpackage

>>> design/gfinv_if.sv
// valid/ready channels of the gf(2^8) inverter
// depends on gfinv_pkg
interface gfinv_in_if;
    logic                 valid;
    logic                 ready;
    gfinv_pkg::t_byte     value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface gfinv_out_if;
    logic                 valid;
    logic                 ready;
    gfinv_pkg::t_byte     additive_inverse;
    gfinv_pkg::t_byte     multiplicative_inverse;

    modport source (output valid, output additive_inverse, output multiplicative_inverse,
                    input ready);
    modport sink   (input valid, input additive_inverse, input multiplicative_inverse,
                    output ready);
endinterface

>>> design/gfinv_mul.sv
// digit-serial gf(2^8) multiplier with operand loading for the inversion chain
// depends on gfinv_pkg
module gfinv_mul #(
    parameter int DIGIT_W = gfinv_pkg::GFI_DIGIT_W
) (
    input  logic                i_clk,
    input  gfinv_pkg::t_gfi_ctl i_ctl,
    input  gfinv_pkg::t_byte    i_value,
    output gfinv_pkg::t_byte    o_x,
    output gfinv_pkg::t_byte    o_acc
);
    import gfinv_pkg::*;

    t_byte r_x;
    t_byte r_a;
    t_byte r_b;
    t_byte r_acc;
    t_byte n_acc;
    t_byte n_a;
    t_byte n_b;

    // msb-first horner over one digit of the serial operand
    always_comb begin
        n_acc = r_acc;
        for (int k = 0; k < DIGIT_W; k++) begin
            n_acc = gf_xtime(n_acc) ^ (r_b[GFI_BYTE_W-1-k] ? r_a : '0);
        end
    end

    // operands of the next product, from the one just finished and the byte
    always_comb begin
        case (i_ctl.step)
            STEP_X63: begin
                n_a = n_acc;
                n_b = gf_sq3(n_acc);
            end
            default: begin
                n_a = r_x;
                n_b = gf_sq(n_acc);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x   <= i_value;
            r_a   <= i_value;
            r_b   <= gf_sq(i_value);
            r_acc <= '0;
        end else if (i_ctl.next) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_acc <= '0;
        end else if (i_ctl.run) begin
            r_b   <= r_b << DIGIT_W;
            r_acc <= n_acc;
        end
    end

    assign o_x   = r_x;
    assign o_acc = r_acc;

endmodule

>>> design/gfinv_ctrl.sv
// sequencer for the inversion chain: digit and product counters, handshake
// depends on gfinv_pkg
module gfinv_ctrl #(
    parameter int DIGIT_W = gfinv_pkg::GFI_DIGIT_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_free,
    output logic                o_in_ready,
    output gfinv_pkg::t_gfi_ctl o_ctl
);
    import gfinv_pkg::*;

    localparam int NDIG = GFI_BYTE_W / DIGIT_W;
    localparam int DIG_CW = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam logic [DIG_CW-1:0] DIG_LAST = DIG_CW'(NDIG - 1);

    t_state            r_state;
    t_state            n_state;
    logic [DIG_CW-1:0] r_dig;
    logic [DIG_CW-1:0] n_dig;
    t_step             r_step;
    t_step             n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dig   <= '0;
            r_step  <= STEP_X3;
        end else begin
            r_state <= n_state;
            r_dig   <= n_dig;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_dig      = r_dig;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_ctl      = '0;
        o_ctl.step = r_step;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_RUN;
                    n_dig      = '0;
                    n_step     = STEP_X3;
                end
            end
            ST_RUN: begin
                o_ctl.run = 1'b1;
                n_dig     = r_dig + 1'b1;
                if (r_dig == DIG_LAST) begin
                    n_dig = '0;
                    if (r_step == STEP_X127) begin
                        n_state = ST_DONE;
                    end else begin
                        o_ctl.next = 1'b1;
                        n_step     = step_succ(r_step);
                        o_ctl.step = n_step;
                    end
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_ctl.out_load = 1'b1;
                    o_in_ready     = 1'b1;
                    n_state        = ST_IDLE;
                    // output register takes the old byte on the same edge
                    if (i_in_valid) begin
                        o_ctl.load = 1'b1;
                        n_state    = ST_RUN;
                        n_dig      = '0;
                        n_step     = STEP_X3;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/gf256_inverse.sv
// Inverse of a byte in GF(2^8) modulo x^8+x^4+x^3+x+1; zero maps to zero, and the
// additive inverse is the byte itself. The inverse is formed as value^254 with the
// chain x^3, x^7, x^63, x^127 and one final squaring, so four field products run
// one after another through a single digit-serial multiplier that takes DIGIT_W
// bits of its serial operand per cycle. Once the output register is free, the
// result is handed to it, and the next byte is taken on that same edge, so a new
// byte is accepted only after the previous result has reached the output
// register. The output register holds a finished result while the next byte is
// already being worked. DIGIT_W must divide 8.
module gf256_inverse #(
    parameter int DIGIT_W = gfinv_pkg::GFI_DIGIT_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gfinv_in_if.sink           i_in,
    gfinv_out_if.source        o_out
);
    import gfinv_pkg::*;

    t_gfi_ctl w_ctl;
    t_byte    w_x;
    t_byte    w_acc;
    logic     w_out_free;
    logic     r_out_valid;
    t_byte    r_out_add;
    t_byte    r_out_mul;

    assign w_out_free = !r_out_valid || o_out.ready;

    gfinv_ctrl #(
        .DIGIT_W (DIGIT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (w_out_free),
        .o_in_ready (i_in.ready),
        .o_ctl      (w_ctl)
    );

    gfinv_mul #(
        .DIGIT_W (DIGIT_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_value (i_in.value),
        .o_x     (w_x),
        .o_acc   (w_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // last squaring turns x^127 into x^254
    always_ff @(posedge i_clk) begin
        if (w_ctl.out_load) begin
            r_out_add <= w_x;
            r_out_mul <= gf_sq(w_acc);
        end
    end

    assign o_out.valid                  = r_out_valid;
    assign o_out.additive_inverse       = r_out_add;
    assign o_out.multiplicative_inverse = r_out_mul;

endmodule

>>> design/gfinv_chk.sv
// port-level checks for gf256_inverse, bound to every instance
// depends on gfinv_pkg and assert_macros.svh
`include "assert_macros.svh"

module gfinv_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input gfinv_pkg::t_byte i_out_add,
    input gfinv_pkg::t_byte i_out_mul
);
    import gfinv_pkg::*;

    // a stalled result beat holds
    `GFI_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_add) && $stable(i_out_mul))

    // one byte in flight: busy right after a beat is taken
    `GFI_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)

    // zero and one are their own inverses
    `GFI_ASSERT(a_fixed_points, i_clk, i_rst_n, i_out_valid && (i_out_add == 8'h00 || i_out_add == 8'h01) |-> i_out_mul == i_out_add)

    `GFI_ASSERT_RST(a_reset_clears_out, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind gf256_inverse gfinv_chk u_gfinv_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_add   (o_out.additive_inverse),
    .i_out_mul   (o_out.multiplicative_inverse)
);

>>> test/tb_gf256_inverse.sv
`timescale 1ns / 100ps
// self-checking bench for gf256_inverse: random and corner bytes in, inverse pairs checked
// depends on gfinv_pkg, gfinv_if and gf256_inverse
module tb_gf256_inverse;
    import gfinv_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 1600;
    localparam int MAX_GAP      = 8;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        t_byte add_inv;
        t_byte mul_inv;
    } inverse_pair_t;

    logic clk;
    logic rst_n;

    gfinv_in_if  in_bus ();
    gfinv_out_if out_bus ();

    gf256_inverse i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_byte         value_q[$];
    inverse_pair_t inverse_q[$];

    logic in_beat;
    logic out_beat;
    int   items_total;
    int   items_taken;
    int   errors;
    int   cycle_count;
    int   send_gap;
    int   recv_gap;
    bit   send_burst;
    bit   recv_burst;

    // multiply by x modulo x^8+x^4+x^3+x+1
    function automatic t_byte times_x(input t_byte a);
        t_byte r;
        r = t_byte'(a << 1);
        if (a[7]) begin
            r = r ^ 8'h1B;
        end
        return r;
    endfunction

    function automatic t_byte field_mul(input t_byte a, input t_byte b);
        t_byte acc;
        t_byte sh;
        acc = '0;
        sh  = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ sh;
            end
            sh = times_x(sh);
        end
        return acc;
    endfunction

    // a^254 is the inverse for nonzero a and zero for zero
    function automatic t_byte gf_inverse_of(input t_byte a);
        t_byte       r;
        t_byte       base;
        logic [7:0]  e;
        r    = 8'h01;
        base = a;
        e    = 8'd254;
        for (int i = 0; i < 8; i++) begin
            if (e[i]) begin
                r = field_mul(r, base);
            end
            base = field_mul(base, base);
        end
        return r;
    endfunction

    initial begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // input driver: one byte per beat, random gap after each
    always @(negedge clk) begin
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_beat) begin
            if (send_gap > 0) begin
                send_gap--;
                in_bus.valid <= 1'b0;
                in_bus.value <= t_byte'($urandom);
            end else if (value_q.size() > 0) begin
                in_bus.valid <= 1'b1;
                in_bus.value <= value_q.pop_front();
                if ($urandom_range(0, 63) == 0) begin
                    send_burst = !send_burst;
                end
                send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // result side back-pressure, redrawn after each beat
    always @(negedge clk) begin
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_beat) begin
                if ($urandom_range(0, 63) == 0) begin
                    recv_burst = !recv_burst;
                end
                recv_gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // monitor: record accepted bytes, check results in order
    always @(posedge clk) begin
        inverse_pair_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, inverse_q.size());
            $display("== FAIL ==");
            $finish;
        end
        if (!rst_n) begin
            in_beat  <= 1'b0;
            out_beat <= 1'b0;
        end else begin
            in_beat  <= in_bus.valid && in_bus.ready;
            out_beat <= out_bus.valid && out_bus.ready;
            if (out_bus.valid && out_bus.ready) begin
                if (inverse_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result add=%02h mul=%02h", $time,
                             out_bus.additive_inverse, out_bus.multiplicative_inverse);
                end else begin
                    want = inverse_q.pop_front();
                    if (out_bus.additive_inverse !== want.add_inv) begin
                        errors++;
                        $display("%0t: additive_inverse expected %02h actual %02h", $time,
                                 want.add_inv, out_bus.additive_inverse);
                    end
                    if (out_bus.multiplicative_inverse !== want.mul_inv) begin
                        errors++;
                        $display("%0t: multiplicative_inverse of %02h expected %02h actual %02h",
                                 $time, want.add_inv, want.mul_inv,
                                 out_bus.multiplicative_inverse);
                    end
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                want.add_inv = in_bus.value;
                want.mul_inv = gf_inverse_of(in_bus.value);
                inverse_q.push_back(want);
                items_taken++;
            end
        end
    end

    initial begin
        t_byte corner[$];
        rst_n         = 1'b0;
        in_bus.valid  = 1'b0;
        in_bus.value  = '0;
        out_bus.ready = 1'b0;
        in_beat       = 1'b0;
        out_beat      = 1'b0;
        items_taken   = 0;
        errors        = 0;
        cycle_count   = 0;
        send_gap      = 0;
        recv_gap      = 0;
        send_burst    = 1'b0;
        recv_burst    = 1'b0;

        // zero, one, all ones, single bits, the textbook pair and the reduction byte
        corner = '{8'h00, 8'h01, 8'hFF, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04,
                   8'h02, 8'h03, 8'h53, 8'hCA, 8'h1B, 8'h8D, 8'hFE, 8'h7F, 8'hAA,
                   8'h55, 8'h00, 8'h00, 8'h01};
        foreach (corner[i]) begin
            value_q.push_back(corner[i]);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            value_q.push_back(t_byte'($urandom_range(0, 255)));
        end
        items_total = value_q.size();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (items_taken < items_total || inverse_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
